// ===== sv/pmc_pkg.sv =====
// ----------------------------------------------------------------------------
// pmc_pkg: shared types and constants of the phase minimum consensus node
// Word layouts of both channels, the configuration image, the descriptor of
// a result burst and the codes used across the node.
// ----------------------------------------------------------------------------
package pmc_pkg;

  // packed id slots in the neighbor id registers
  localparam int ID_SLOTS   = 8;
  localparam int SLOT_IDX_W = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [7:0] COUNT_MAX = 8'd255;

  // request codes
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_MSG   = 1'b1;

  // result kinds
  localparam logic KIND_SEND   = 1'b0;
  localparam logic KIND_DECIDE = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIAMETER    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_COUNT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_COUNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_VALUE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_IDS      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_IDS     = 3'd5;

  // configuration reset values
  localparam logic [7:0] DIAMETER_RST  = 8'd5;
  localparam logic [3:0] IN_COUNT_RST  = 4'd1;
  localparam logic [3:0] OUT_COUNT_RST = 4'd1;

  typedef struct packed {
    logic               req_type;
    logic [7:0]         source_id;
    logic signed [31:0] msg_value;
  } in_word_t;

  typedef struct packed {
    logic               out_kind;
    logic [7:0]         dest_id;
    logic signed [31:0] out_value;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic [7:0]              diameter;
    logic [3:0]              in_count;
    logic [3:0]              out_count;
    logic signed [31:0]      start_value;
    logic [ID_SLOTS*8-1:0]   in_ids;
    logic [ID_SLOTS*8-1:0]   out_ids;
  } cfg_t;

  // one item's results: a single decision or one send per out-neighbor
  typedef struct packed {
    logic                  valid;
    logic                  kind;
    logic signed [31:0]    value;
    logic [SLOT_IDX_W-1:0] last_idx;
  } burst_t;

endpackage

// ===== sv/pmc_node.sv =====
// ----------------------------------------------------------------------------
// pmc_node: protocol state of one consensus node
// Holds the running minimum, round and receive counters, and turns one item
// into a result burst descriptor in a single pass.
// ----------------------------------------------------------------------------
module pmc_node
  import pmc_pkg::*;
#(
  parameter int MAX_IN_NEIGHBORS  = 8,
  parameter int MAX_OUT_NEIGHBORS = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     step_en,
  input  in_word_t item,
  output burst_t   burst
);

  localparam int InSlots  = (MAX_IN_NEIGHBORS  < ID_SLOTS) ? MAX_IN_NEIGHBORS  : ID_SLOTS;
  localparam int OutSlots = (MAX_OUT_NEIGHBORS < ID_SLOTS) ? MAX_OUT_NEIGHBORS : ID_SLOTS;

  logic signed [31:0] min_r;
  logic [7:0]         rounds_r;
  logic               fin_r;
  logic [7:0]         cnt_r [InSlots];

  logic signed [31:0] min_nxt;
  logic [7:0]         rounds_base;
  logic [7:0]         rounds_nxt;
  logic               fin_nxt;
  logic [7:0]         cnt_nxt [InSlots];
  logic [InSlots-1:0] hit;
  logic [3:0]         n_in;
  logic [3:0]         n_out;
  logic               is_start;
  logic               active;
  logic               found;
  logic               ge_dia;
  logic               ge_rnd;
  logic               decide;
  logic               send;

  always_comb begin
    is_start = (item.req_type == REQ_START);
    active   = is_start || !fin_r;
    n_in     = (cfg.in_count  > 4'(InSlots))  ? 4'(InSlots)  : cfg.in_count;
    n_out    = (cfg.out_count > 4'(OutSlots)) ? 4'(OutSlots) : cfg.out_count;

    if (is_start) begin
      min_nxt = cfg.start_value;
    end else if (item.msg_value < min_r) begin
      min_nxt = item.msg_value;
    end else begin
      min_nxt = min_r;
    end
    rounds_base = is_start ? 8'd0 : rounds_r;

    // count the sender in its first matching in-use slot
    found = 1'b0;
    for (int i = 0; i < InSlots; i++) begin
      hit[i] = !found && (4'(i) < n_in) && (cfg.in_ids[8*i +: 8] == item.source_id);
      found  = found | hit[i];
      if (is_start) begin
        cnt_nxt[i] = 8'd0;
      end else if (hit[i] && (cnt_r[i] != COUNT_MAX)) begin
        cnt_nxt[i] = cnt_r[i] + 8'd1;
      end else begin
        cnt_nxt[i] = cnt_r[i];
      end
    end

    ge_dia = 1'b1;
    ge_rnd = 1'b1;
    for (int i = 0; i < InSlots; i++) begin
      if (4'(i) < n_in) begin
        if (cnt_nxt[i] < cfg.diameter) ge_dia = 1'b0;
        if (cnt_nxt[i] < rounds_base)  ge_rnd = 1'b0;
      end
    end

    decide     = !is_start && ge_dia;
    send       = !decide && (rounds_base < cfg.diameter) && ge_rnd;
    rounds_nxt = rounds_base + 8'(send);
    fin_nxt    = is_start ? 1'b0 : (decide | fin_r);

    burst.valid    = active && (decide || (send && (n_out != 4'd0)));
    burst.kind     = decide ? KIND_DECIDE : KIND_SEND;
    burst.value    = min_nxt;
    burst.last_idx = decide ? '0 : SLOT_IDX_W'(n_out - 4'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r    <= '0;
      rounds_r <= '0;
      fin_r    <= 1'b0;
      for (int i = 0; i < InSlots; i++) cnt_r[i] <= '0;
    end else if (step_en && active) begin
      min_r    <= min_nxt;
      rounds_r <= rounds_nxt;
      fin_r    <= fin_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== sv/phase_min_consensus_node_unit.sv =====
// ----------------------------------------------------------------------------
// phase_min_consensus_node_unit: one node of the phase minimum algorithm
// Tracks the network-wide minimum, emits one send per out-neighbor each
// round and a single decision once every in-neighbor has delivered all its
// rounds.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+------------------------------
//  in_     | input     | in_valid / in_stall   | req_type, source_id, msg_value
//  out_    | output    | out_valid / out_stall | out_kind, dest_id, out_value,
//          |           |                       | last
//  cfg_    | input     | cfg_we                | cfg_index, cfg_wdata
//
//  An accepted word waits in the input register until the result register
//  is free; then the node state updates and its results load the result
//  register. A word causing k results (k is 0, 1 or out_count up to 8)
//  holds the result register until its last result is handed off: the
//  burst sequencer walks the out-neighbor slots. Words with at most one
//  result flow at one per cycle while out_stall is low.
//  out_stall freezes the result register; in_stall rises only while the input
//  register is full and the result register holds a burst that does not hand
//  off its last word in this cycle.
//  rst_n is synchronous: it clears node state, pipeline valids and restores
//  the configuration defaults.
//
module phase_min_consensus_node_unit
  import pmc_pkg::*;
#(
  parameter int MAX_IN_NEIGHBORS  = 8,
  parameter int MAX_OUT_NEIGHBORS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data,
  // configuration port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t                  cfg_r;

  logic                  in_valid_r;
  in_word_t              in_word_r;

  burst_t                burst;
  logic                  b_valid_r;
  logic                  b_kind_r;
  logic signed [31:0]    b_value_r;
  logic [SLOT_IDX_W-1:0] b_last_r;
  logic [SLOT_IDX_W-1:0] b_idx_r;

  logic                  out_last;
  logic                  burst_done;
  logic                  burst_free;
  logic                  advance;

  // ---- configuration registers -------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.diameter    <= DIAMETER_RST;
      cfg_r.in_count    <= IN_COUNT_RST;
      cfg_r.out_count   <= OUT_COUNT_RST;
      cfg_r.start_value <= '0;
      cfg_r.in_ids      <= '0;
      cfg_r.out_ids     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIAMETER:    cfg_r.diameter    <= cfg_wdata[7:0];
        CFG_IN_COUNT:    cfg_r.in_count    <= cfg_wdata[3:0];
        CFG_OUT_COUNT:   cfg_r.out_count   <= cfg_wdata[3:0];
        CFG_START_VALUE: cfg_r.start_value <= cfg_wdata[31:0];
        CFG_IN_IDS:      cfg_r.in_ids      <= cfg_wdata;
        CFG_OUT_IDS:     cfg_r.out_ids     <= cfg_wdata;
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // ---- handshake control -------------------------------------------------
  // The result register frees up when empty or on the handoff of its last word.
  assign out_last   = (b_idx_r == b_last_r);
  assign burst_done = b_valid_r && !out_stall && out_last;
  assign burst_free = !b_valid_r || burst_done;
  assign advance    = in_valid_r && burst_free;
  assign in_stall   = in_valid_r && !burst_free;

  // ---- input register ----------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_word_r <= in_data;
    end
  end

  // ---- node state and result decision -------------------------------------
  pmc_node #(
    .MAX_IN_NEIGHBORS  (MAX_IN_NEIGHBORS),
    .MAX_OUT_NEIGHBORS (MAX_OUT_NEIGHBORS)
  ) u_node (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .step_en (advance),
    .item    (in_word_r),
    .burst   (burst)
  );

  // ---- result register and burst sequencer --------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      b_idx_r   <= '0;
    end else if (advance) begin
      // load the next burst, start at out-neighbor slot 0
      b_valid_r <= burst.valid;
      b_idx_r   <= '0;
    end else if (burst_done) begin
      b_valid_r <= 1'b0;
    end else if (b_valid_r && !out_stall) begin
      b_idx_r   <= b_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_kind_r  <= burst.kind;
      b_value_r <= burst.value;
      b_last_r  <= burst.last_idx;
    end
  end

  assign out_valid          = b_valid_r;
  assign out_data.out_kind  = b_kind_r;
  assign out_data.dest_id   = (b_kind_r == KIND_SEND) ? cfg_r.out_ids[8*b_idx_r +: 8] : 8'd0;
  assign out_data.out_value = b_value_r;
  assign out_data.last      = out_last;

  // ---- assertions --------------------------------------------------------
  a_stall_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_valid_r && b_valid_r))
    else $error("input stalled while the result register can take a burst");

  a_idx_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |-> (b_idx_r <= b_last_r))
    else $error("burst slot index ran past the last out-neighbor");

  a_decide_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && (b_kind_r == KIND_DECIDE)) |-> out_last)
    else $error("decision is not the only word of its burst");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && out_stall) |=> (b_valid_r && $stable(b_idx_r)))
    else $error("burst advanced while the result channel stalled");

endmodule
